### rtl/core/plls_pkg.sv
package plls_pkg;

  localparam int POS_WIDTH = 24;
  localparam int SAMPLE_W = 8;
  localparam int OFFSET_W = 24;
  localparam int SPAN_W = 24;
  localparam int COUNT_W = 23;
  localparam int HIST_W = 32;

  localparam logic [HIST_W-1:0] TAP_MASK = 32'h8040_1020;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] MIN_RUN = POS_WIDTH'(64 * 3);
  localparam logic [POS_WIDTH-1:0] SPAN_ADJ = POS_WIDTH'(63 * 3);
  localparam logic [63:0] START_ADJ = 64'(32 * 3 - 2);

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [HIST_W-1:0] hist_t;

  typedef struct packed {
    pos_t start;
    pos_t length;
  } run_t;

endpackage

### rtl/core/plls_if.sv
interface plls_in_if import plls_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_byte;
  logic                last_byte;

  modport source(output valid, sample_byte, last_byte, input ready);
  modport sink(input valid, sample_byte, last_byte, output ready);
endinterface

interface plls_out_if import plls_pkg::*;;
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] start_offset;
  logic [SPAN_W-1:0]   span_bytes;
  logic [COUNT_W-1:0]  sample_count;

  modport source(output valid, found, start_offset, span_bytes, sample_count, input ready);
  modport sink(input valid, found, start_offset, span_bytes, sample_count, output ready);
endinterface

### rtl/core/plls_track.sv
module plls_track import plls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  plls_in_if.sink   samples,
  output logic      run_valid,
  input  logic      run_ready,
  output run_t      run
);

  logic  in_valid;
  logic  in_bit;
  logic  in_last;
  logic  fire;

  hist_t hist_one_back;
  hist_t hist_two_back;
  hist_t hist_three_back;
  pos_t  bad_one_back;
  pos_t  bad_two_back;
  pos_t  bad_three_back;
  pos_t  best_start;
  pos_t  best_length;
  pos_t  byte_position;

  hist_t hist_next;
  logic  predicted;
  logic  bad;
  pos_t  run_dist;
  logic  take;
  pos_t  bad_next;
  pos_t  best_start_next;
  pos_t  best_length_next;

  assign fire = in_valid && (!in_last || run_ready);
  assign samples.ready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_bit  <= samples.sample_byte[0];
      in_last <= samples.last_byte;
    end
  end

  // prediction and lane ordering check
  always_comb begin
    predicted = ^(hist_three_back & TAP_MASK);
    hist_next = {hist_three_back[HIST_W-2:0], in_bit};
    bad = (|(hist_next & ~hist_one_back)) || (|(hist_two_back & ~hist_next))
          || (predicted != in_bit);
    run_dist = byte_position - bad_three_back;
    take = !bad && (run_dist >= best_length);
    bad_next = bad ? byte_position : bad_three_back;
    best_start_next = take ? bad_three_back : best_start;
    best_length_next = take ? run_dist : best_length;
  end

  assign run_valid = in_valid && in_last;
  assign run.start = best_start_next;
  assign run.length = best_length_next;

  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      hist_one_back   <= '0;
      hist_two_back   <= '0;
      hist_three_back <= '0;
      bad_one_back    <= '0;
      bad_two_back    <= '0;
      bad_three_back  <= '0;
      best_start      <= '0;
      best_length     <= '0;
      byte_position   <= '0;
    end else if (fire) begin
      hist_three_back <= hist_two_back;
      hist_two_back   <= hist_one_back;
      hist_one_back   <= hist_next;
      bad_three_back  <= bad_two_back;
      bad_two_back    <= bad_one_back;
      bad_one_back    <= bad_next;
      best_start      <= best_start_next;
      best_length     <= best_length_next;
      if (byte_position != POS_MAX) begin
        byte_position <= byte_position + POS_WIDTH'(1);
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> byte_position == '0 && best_length == '0)
    else $error("state not cleared after last byte");

  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    best_length <= byte_position && best_start <= byte_position)
    else $error("best run exceeds position");

  a_hold_on_blocked_last: assert property (@(posedge clk) disable iff (rst)
    run_valid && !run_ready |-> !samples.ready)
    else $error("input taken while last byte is blocked");

endmodule

### rtl/core/plls_fmt.sv
module plls_fmt import plls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       run_valid,
  output logic       run_ready,
  input  run_t       run,
  plls_out_if.source results
);

  localparam int RECIP_SHIFT = POS_WIDTH + 1;
  localparam int PROD_W = 2 * POS_WIDTH + 1;
  localparam logic [POS_WIDTH:0] DIV3_RECIP =
    (POS_WIDTH + 1)'(((longint'(1) << RECIP_SHIFT) + 2) / 3);

  logic  v1;
  run_t  run_q;
  logic  v2;
  logic  found_q;
  logic  [OFFSET_W-1:0] start_q;
  pos_t  span_q;
  logic  v3;
  logic  found_o;
  logic  [OFFSET_W-1:0] start_o;
  logic  [SPAN_W-1:0] span_o;
  logic  [COUNT_W-1:0] count_o;

  logic  mv1;
  logic  mv2;
  logic  free2;
  logic  free3;

  logic  found_c;
  logic  [63:0] start_wide;
  logic  [PROD_W-1:0] prod;
  logic  [63:0] quot_wide;

  assign free3 = !v3 || results.ready;
  assign mv2 = v2 && free3;
  assign free2 = !v2 || mv2;
  assign mv1 = v1 && free2;
  assign run_ready = !v1 || mv1;

  always_comb begin
    found_c = run_q.length >= MIN_RUN;
    start_wide = 64'(run_q.start) + START_ADJ;
    prod = PROD_W'(span_q) * PROD_W'(DIV3_RECIP);
    quot_wide = 64'(prod[PROD_W-1:RECIP_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (run_valid && run_ready) begin
        v1 <= 1'b1;
      end else if (mv1) begin
        v1 <= 1'b0;
      end
      if (mv1) begin
        v2 <= 1'b1;
      end else if (mv2) begin
        v2 <= 1'b0;
      end
      if (mv2) begin
        v3 <= 1'b1;
      end else if (results.ready) begin
        v3 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_valid && run_ready) begin
      run_q <= run;
    end
    if (mv1) begin
      found_q <= found_c;
      start_q <= found_c ? start_wide[OFFSET_W-1:0] : '0;
      span_q  <= found_c ? run_q.length - SPAN_ADJ : '0;
    end
    if (mv2) begin
      found_o <= found_q;
      start_o <= start_q;
      span_o  <= SPAN_W'(64'(span_q));
      count_o <= quot_wide[COUNT_W-1:0];
    end
  end

  assign results.valid = v3;
  assign results.found = found_o;
  assign results.start_offset = start_o;
  assign results.span_bytes = span_o;
  assign results.sample_count = count_o;

  a_empty_when_not_found: assert property (@(posedge clk) disable iff (rst)
    v3 && !found_o |-> span_o == '0 && start_o == '0 && count_o == '0)
    else $error("nonzero result without a run");

  a_span_floor: assert property (@(posedge clk) disable iff (rst)
    v2 && found_q |-> span_q >= POS_WIDTH'(3))
    else $error("span below minimum for a found run");

endmodule

### rtl/core/prbs_lock_search_three_lane_unit.sv
// channel   | role   | payload                                          | transfer
// samples   | sink   | sample_byte[7:0], last_byte                      | valid && ready
// results   | source | found, start_offset[23:0], span_bytes[23:0],     | valid && ready
//           |        | sample_count[22:0]                               |
// one byte per cycle unless a last byte is blocked
// lane state updates as a byte leaves the input register
// synchronous rst clears all lane histories, error positions and the best run
// results stall through a three-deep result pipeline; samples stall only when
// a last byte cannot enter it
module prbs_lock_search_three_lane_unit import plls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  plls_in_if.sink    samples,
  plls_out_if.source results
);

  logic run_valid;
  logic run_ready;
  run_t run;

  plls_track u_track (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run       (run)
  );

  plls_fmt u_fmt (
    .clk       (clk),
    .rst       (rst),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run       (run),
    .results   (results)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import plls_pkg::*;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] start;
    logic [SPAN_W-1:0]   span;
    logic [COUNT_W-1:0]  count;
  } lock_report_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic clk;
  logic rst;

  plls_in_if  sample_ch();
  plls_out_if result_ch();

  prbs_lock_search_three_lane_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch)
  );

  // lane state of the search, newest to oldest
  hist_t hist_new, hist_mid, hist_old;
  pos_t  err_new, err_mid, err_old;
  pos_t  run_start, run_len, byte_pos;

  lock_report_t pending_reports[$];

  int  failures;
  int  accepted_bytes;
  int  burst_left;
  bit  gaps_enabled;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  task automatic clear_lanes();
    hist_new = '0;
    hist_mid = '0;
    hist_old = '0;
    err_new = '0;
    err_mid = '0;
    err_old = '0;
    run_start = '0;
    run_len = '0;
    byte_pos = '0;
  endtask

  task automatic predict_byte(input logic [SAMPLE_W-1:0] sb, input logic lb);
    hist_t        nxt;
    pos_t         err_pos;
    pos_t         run_dist;
    pos_t         span_p;
    lock_report_t rep;
    nxt = {hist_old[HIST_W-2:0], sb[0]};
    err_pos = err_old;
    if (((nxt & ~hist_new) != '0) || ((hist_mid & ~nxt) != '0) ||
        ((^(hist_old & TAP_MASK)) != sb[0])) begin
      err_pos = byte_pos;
    end else begin
      run_dist = byte_pos - err_old;
      if (run_dist >= run_len) begin
        run_start = err_old;
        run_len = run_dist;
      end
    end
    err_old = err_mid;
    err_mid = err_new;
    err_new = err_pos;
    hist_old = hist_mid;
    hist_mid = hist_new;
    hist_new = nxt;
    if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
    if (lb) begin
      rep = '0;
      if (run_len >= MIN_RUN) begin
        span_p = run_len - SPAN_ADJ;
        rep.found = 1'b1;
        rep.start = OFFSET_W'(64'(run_start) + START_ADJ);
        rep.span = SPAN_W'(span_p);
        rep.count = COUNT_W'(span_p / 3);
      end
      pending_reports.push_back(rep);
      clear_lanes();
    end
  endtask

  task automatic send_byte(input logic [SAMPLE_W-1:0] sb, input logic lb);
    @(negedge clk);
    if (gaps_enabled && burst_left <= 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample_byte <= sb;
    sample_ch.last_byte <= lb;
    do @(posedge clk); while (!sample_ch.ready);
    predict_byte(sb, lb);
    accepted_bytes++;
    burst_left--;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
  endtask

  // bit stream follows the tap recurrence after a random seed, each symbol
  // spread over the three lanes, with optional bit flips and lane slips
  task automatic send_prbs_buffer(input int len, input int seed_syms,
                                  input int flip_permille, input int slip_permille);
    hist_t gen;
    int    sent;
    int    sym;
    int    reps;
    logic  b;
    logic  bb;
    gen = '0;
    sent = 0;
    sym = 0;
    while (sent < len) begin
      if (sym < seed_syms) b = 1'($urandom_range(0, 1));
      else b = ^(gen & TAP_MASK);
      gen = {gen[HIST_W-2:0], b};
      sym++;
      reps = 3;
      if ($urandom_range(0, 999) < slip_permille) reps = $urandom_range(0, 1) ? 2 : 4;
      for (int r = 0; r < reps && sent < len; r++) begin
        bb = b;
        if ($urandom_range(0, 999) < flip_permille) bb = ~b;
        sent++;
        send_byte({7'($urandom), bb}, sent == len);
      end
    end
  endtask

  task automatic send_noise_buffer(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  task automatic log_failure(input string what, input lock_report_t want,
                             input lock_report_t got);
    failures++;
    if (failures <= 10)
      $display("%s: want found=%0b start=%0d span=%0d count=%0d, %s%0b %s%0d %s%0d %s%0d",
               what, want.found, want.start, want.span, want.count,
               "got found=", got.found, "start=", got.start,
               "span=", got.span, "count=", got.count);
  endtask

  // result checker
  always @(posedge clk) begin
    lock_report_t got;
    lock_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.found = result_ch.found;
      got.start = result_ch.start_offset;
      got.span = result_ch.span_bytes;
      got.count = result_ch.sample_count;
      if (pending_reports.size() == 0) begin
        log_failure("unexpected result", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.found !== want.found || got.start !== want.start ||
            got.span !== want.span || got.count !== want.count)
          log_failure("result mismatch", want, got);
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off on request
  initial begin
    int       hold_left;
    int       mode_left;
    rx_mode_e rx_mode;
    hold_left = 0;
    mode_left = 0;
    rx_mode = RX_OPEN;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (mode_left <= 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   result_ch.ready <= 1'b1;
          RX_LIGHT:  result_ch.ready <= ($urandom_range(0, 9) < 7);
          RX_HEAVY:  result_ch.ready <= ($urandom_range(0, 9) < 2);
          RX_TOGGLE: result_ch.ready <= mode_left[0];
          default:   result_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // field extremes, unused upper bits, one-byte buffers and a three-byte buffer
  task automatic test_single_bytes();
    gaps_enabled = 1'b0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b1);
    idle_sender();
  endtask

  // clean runs just under and at the minimum length
  task automatic test_run_threshold();
    gaps_enabled = 1'b0;
    send_prbs_buffer(192, 0, 0, 0);
    send_prbs_buffer(193, 0, 0, 0);
    idle_sender();
  endtask

  // results held off while last bytes keep coming
  task automatic test_backpressure();
    gaps_enabled = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_byte(8'($urandom), 1'b1);
    send_prbs_buffer(100, 20, 2, 0);
    idle_sender();
  endtask

  task automatic test_random_buffers();
    int start_bytes;
    int len;
    start_bytes = accepted_bytes;
    while (accepted_bytes - start_bytes < 250) begin
      gaps_enabled = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: send_noise_buffer($urandom_range(1, 40));
        1: send_prbs_buffer($urandom_range(185, 200), $urandom_range(0, 3), 0, 0);
        2: send_prbs_buffer($urandom_range(150, 450), $urandom_range(1, 36), 0, 8);
        default: begin
          len = $urandom_range(150, 420);
          send_prbs_buffer(len, $urandom_range(0, 36), $urandom_range(0, 6), 2);
        end
      endcase
    end
    idle_sender();
  endtask

  initial begin
    failures = 0;
    accepted_bytes = 0;
    burst_left = 0;
    gaps_enabled = 1'b0;
    hold_req = 1'b0;
    clear_lanes();
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.sample_byte <= '0;
    sample_ch.last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_bytes();
    test_run_threshold();
    test_backpressure();
    test_random_buffers();

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
